### hw/rtl/mcht_pkg.sv
`default_nettype none
package mcht_pkg;
    localparam int unsigned POOL_SLOTS_DEF = 128;
    localparam int unsigned BUCKETS_DEF    = 19;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_REMOVED = 3'd1;
    localparam logic [2:0] ST_PRESENT = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_WALK,
        S_FREE,
        S_APPEND,
        S_UNLINK,
        S_DONE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;       // latch input item, start hash
        logic hash_step;  // add one MAC byte or do one reduce step
        logic head_rd;    // read bucket head and size
        logic walk_rd;    // read current chain slot
        logic walk_adv;   // advance to link
        logic free_step;  // scan one slot for free
        logic do_add;     // write new entry, link it
        logic do_del;     // unlink hit entry
        logic set_res;    // latch result
        logic [2:0] res_status;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic hash_done;
        logic chain_end;  // current pointer is NO_SLOT or step limit reached
        logic match;      // current slot matches key
        logic free_found;
        logic free_end;
        logic kind;
    } t_sts;
endpackage
`default_nettype wire

### hw/rtl/mcht_ctrl.sv
`default_nettype none
module mcht_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    output logic              o_res_valid,
    input  wire logic         i_res_stall,
    input  wire mcht_pkg::t_sts i_sts,
    output mcht_pkg::t_cmd    o_cmd
);
    import mcht_pkg::*;

    t_state r_state, n_state;
    logic   r_res_valid, n_res_valid;
    // wait for the registered slot read before deciding
    logic   r_rd_wait, n_rd_wait;
    // hold the decided status until the result register takes it
    logic [2:0] r_res_status, n_res_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_res_valid  <= 1'b0;
            r_rd_wait    <= 1'b0;
            r_res_status <= ST_ADDED;
        end else begin
            r_state      <= n_state;
            r_res_valid  <= n_res_valid;
            r_rd_wait    <= n_rd_wait;
            r_res_status <= n_res_status;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_res_valid  = r_res_valid;
        n_rd_wait    = 1'b0;
        n_res_status = r_res_status;
        o_cmd        = '0;
        o_cmd.res_status = r_res_status;
        o_in_stall   = 1'b1;
        if (r_res_valid && !i_res_stall) n_res_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_sts.hash_done) n_state = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.head_rd = 1'b1;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (i_sts.chain_end) begin
                    if (i_sts.kind) n_state = S_FREE;
                    else begin
                        n_res_status = ST_ABSENT;
                        n_state = S_DONE;
                    end
                end else if (!r_rd_wait) begin
                    o_cmd.walk_rd = 1'b1;
                    n_rd_wait     = 1'b1;
                end else if (i_sts.match) begin
                    if (i_sts.kind) begin
                        n_res_status = ST_PRESENT;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_UNLINK;
                    end
                end else begin
                    o_cmd.walk_adv = 1'b1;
                end
            end
            S_FREE: begin
                if (i_sts.free_found) n_state = S_APPEND;
                else if (i_sts.free_end) begin
                    n_res_status = ST_FULL;
                    n_state = S_DONE;
                end else o_cmd.free_step = 1'b1;
            end
            S_APPEND: begin
                o_cmd.do_add = 1'b1;
                n_res_status = ST_ADDED;
                n_state = S_DONE;
            end
            S_UNLINK: begin
                o_cmd.do_del = 1'b1;
                n_res_status = ST_REMOVED;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_res_valid || !i_res_stall) begin
                    o_cmd.set_res = 1'b1;
                    n_res_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_res_valid = r_res_valid;
endmodule
`default_nettype wire

### hw/rtl/mcht_dp.sv
`default_nettype none
module mcht_dp #(
    parameter int unsigned POOL_SLOTS = mcht_pkg::POOL_SLOTS_DEF,
    parameter int unsigned BUCKETS    = mcht_pkg::BUCKETS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_kind,
    input  wire logic [2:0]     i_iface,
    input  wire logic [47:0]    i_mac,
    input  wire mcht_pkg::t_cmd i_cmd,
    output mcht_pkg::t_sts      o_sts,
    output logic [2:0]          o_status,
    output logic                o_success,
    output logic [6:0]          o_entry_slot,
    output logic [7:0]          o_active_count
);
    import mcht_pkg::*;

    localparam int unsigned SW = $clog2(POOL_SLOTS + 1);  // slot pointer incl. NO_SLOT
    localparam int unsigned SI = $clog2(POOL_SLOTS);
    localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned CW = $clog2(POOL_SLOTS + 1);
    localparam logic [SW-1:0] NO_SLOT = SW'(POOL_SLOTS);
    // Byte sum is at most 6*255; reduce it by shifted bucket counts, one a cycle.
    localparam int unsigned SUM_MAX   = 6 * 255;
    localparam int unsigned RED       = $clog2(SUM_MAX / BUCKETS + 1);
    localparam int unsigned HASH_LAST = 6 + RED - 1;
    localparam logic [11:0] DIV_TOP   = 12'(BUCKETS << (RED - 1));

    // Slot store: key, link. Reset-free memories.
    logic [50:0]   m_key  [POOL_SLOTS];
    logic [SW-1:0] m_link [POOL_SLOTS];
    logic [POOL_SLOTS-1:0] r_used;
    logic [SW-1:0] r_first [BUCKETS];
    logic [CW-1:0] r_size  [BUCKETS];
    logic [CW-1:0] r_total;

    logic          r_kind;
    logic [2:0]    r_iface;
    logic [47:0]   r_mac;
    logic [3:0]    r_byte;
    logic [11:0]   r_sum;    // byte sum, then reduced mod BUCKETS
    logic [11:0]   r_div;    // current shifted bucket count
    logic [SW-1:0] r_cur, r_prev, r_hit_prev;
    logic [SW:0]   r_steps;
    logic [50:0]   r_rd_key;
    logic [SW-1:0] r_rd_link;
    logic [SI-1:0] r_free;
    logic          r_free_found;
    logic [6:0]    r_slot;

    logic [BW-1:0] w_bkt;
    logic [7:0]    w_byte;
    logic [11:0]   w_add;
    logic [SI-1:0] w_cur, w_prev;
    assign w_bkt  = BW'(r_sum);
    assign w_add  = r_sum + {4'b0, w_byte};
    assign w_cur  = r_cur[SI-1:0];
    assign w_prev = r_prev[SI-1:0];

    always_comb begin
        case (r_byte[2:0])
            3'd0:    w_byte = r_mac[7:0];
            3'd1:    w_byte = r_mac[15:8];
            3'd2:    w_byte = r_mac[23:16];
            3'd3:    w_byte = r_mac[31:24];
            3'd4:    w_byte = r_mac[39:32];
            3'd5:    w_byte = r_mac[47:40];
            default: w_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_iface <= i_iface;
            r_mac   <= i_mac;
            r_byte  <= 4'd0;
            r_sum   <= '0;
            r_div   <= DIV_TOP;
            r_free  <= '0;
        end
        if (i_cmd.hash_step) begin
            if (r_byte < 4'd6) begin
                r_sum <= w_add;
            end else begin
                if (r_sum >= r_div) r_sum <= r_sum - r_div;
                r_div <= r_div >> 1;
            end
            r_byte <= r_byte + 4'd1;
        end
        if (i_cmd.head_rd) begin
            r_cur   <= r_first[w_bkt];
            r_prev  <= NO_SLOT;
            r_steps <= '0;
        end
        if (i_cmd.walk_rd) begin
            r_rd_key  <= m_key[w_cur];
            r_rd_link <= m_link[w_cur];
        end
        if (i_cmd.walk_adv) begin
            r_prev  <= r_cur;
            r_cur   <= r_rd_link;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.free_step) r_free <= r_free + 1'b1;
        if (i_cmd.do_add) begin
            m_key[r_free]  <= {r_iface, r_mac};
            m_link[r_free] <= NO_SLOT;
            r_slot         <= 7'(r_free);
            // append after tail (prev of chain end) when chain not empty
            if (r_prev != NO_SLOT) m_link[w_prev] <= {1'b0, r_free};
        end
        if (i_cmd.do_del) begin
            r_slot <= 7'(w_cur);
            if (r_prev != NO_SLOT) m_link[w_prev] <= r_rd_link;
        end
    end

    logic w_full_scan;
    assign w_full_scan = (r_free == SI'(POOL_SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_total <= '0;
            for (int b = 0; b < BUCKETS; b++) begin
                r_first[b] <= NO_SLOT;
                r_size[b]  <= '0;
            end
        end else begin
            if (i_cmd.do_add) begin
                r_used[r_free] <= 1'b1;
                if (r_prev == NO_SLOT) r_first[w_bkt] <= {1'b0, r_free};
                r_size[w_bkt] <= r_size[w_bkt] + 1'b1;
                r_total <= r_total + 1'b1;
            end
            if (i_cmd.do_del) begin
                r_used[w_cur] <= 1'b0;
                if (r_prev == NO_SLOT) r_first[w_bkt] <= r_rd_link;
                if (r_size[w_bkt] != '0) r_size[w_bkt] <= r_size[w_bkt] - 1'b1;
                if (r_total != '0) r_total <= r_total - 1'b1;
            end
        end
    end

    // Load the result register only when the controller releases a result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            o_status       <= i_cmd.res_status;
            o_active_count <= 8'(r_total);
            if (i_cmd.res_status == ST_ADDED || i_cmd.res_status == ST_REMOVED) begin
                o_success    <= 1'b1;
                o_entry_slot <= r_slot;
            end else begin
                o_success    <= 1'b0;
                o_entry_slot <= '0;
            end
        end
    end

    assign o_sts.hash_done  = (r_byte == 4'(HASH_LAST));
    assign o_sts.chain_end  = (r_cur >= NO_SLOT) || (r_steps >= (SW+1)'(POOL_SLOTS));
    assign o_sts.match      = (r_rd_key == {r_iface, r_mac});
    assign o_sts.free_found = !r_used[r_free];
    assign o_sts.free_end   = w_full_scan && r_used[r_free];
    assign o_sts.kind       = r_kind;
endmodule
`default_nettype wire

### hw/rtl/mac_client_hash_table.sv
`default_nettype none
// Client table: chained hash over a fixed pool of slots.
// Input channel (i_in_valid / o_in_stall) transfers one event: kind
// (1 connect, 0 disconnect), iface and 48-bit MAC. Output channel
// (o_res_valid / i_res_stall) transfers status, success, entry_slot and
// active_count, one result per event, in order.
// Bucket is the MAC byte sum mod BUCKETS: the six bytes are added one a cycle,
// then one compare-and-subtract a cycle against a halving shifted bucket count.
// An event runs through the hash, a head read, the chain walk (a slot read and
// a decision per entry walked), on a connect a free scan that tests one slot
// per step (up to POOL_SLOTS), an append or unlink where the table changes,
// and the done state, which loads the result register and raises o_res_valid.
// One event is in work at a time; the next transfer is taken back in idle,
// after the result is loaded, so the chain walk and the free scan set the rate.
// The result sits in an output register; the next event is taken while
// it waits. If the receiver stalls, a finished result waits in its state
// until the register frees.
// Reset clears the slot-in-use bits, bucket heads, sizes and total at
// once; there is no clearing pass.
module mac_client_hash_table #(
    parameter int unsigned POOL_SLOTS = mcht_pkg::POOL_SLOTS_DEF,
    parameter int unsigned BUCKETS    = mcht_pkg::BUCKETS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_kind,
    input  wire logic [2:0]  i_iface,
    input  wire logic [47:0] i_mac,
    output logic             o_res_valid,
    input  wire logic        i_res_stall,
    output logic [2:0]       o_status,
    output logic             o_success,
    output logic [6:0]       o_entry_slot,
    output logic [7:0]       o_active_count
);
    import mcht_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    mcht_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_res_valid,
        .i_res_stall, .i_sts(w_sts), .o_cmd(w_cmd)
    );

    mcht_dp #(.POOL_SLOTS(POOL_SLOTS), .BUCKETS(BUCKETS)) u_dp (
        .i_clk, .i_rst_n, .i_kind, .i_iface, .i_mac,
        .i_cmd(w_cmd), .o_sts(w_sts),
        .o_status, .o_success, .o_entry_slot, .o_active_count
    );

    // A changed table reports success, an unchanged one does not.
    a_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_success == (o_status == ST_ADDED || o_status == ST_REMOVED)))
        else $error("success disagrees with status");
    // Nothing changed means slot zero.
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_success) |-> (o_entry_slot == 7'd0))
        else $error("slot nonzero without change");
    // Never take a new event while the previous one is being worked.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while busy");
endmodule
`default_nettype wire

### sim/mac_client_checker.sv
module mac_client_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic        i_kind,
    input  wire logic [2:0]  i_iface,
    input  wire logic [47:0] i_mac,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_stall,
    input  wire logic [2:0]  i_status,
    input  wire logic        i_success,
    input  wire logic [6:0]  i_entry_slot,
    input  wire logic [7:0]  i_active_count,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import mcht_pkg::*;

    localparam int NSLOT = POOL_SLOTS_DEF;
    localparam int NBKT  = BUCKETS_DEF;

    typedef struct packed {
        logic [2:0] status;
        logic       success;
        logic [6:0] slot;
        logic [7:0] count;
    } t_outcome;

    t_outcome   outcome_q[$];
    bit         used[NSLOT];
    logic [2:0] s_iface[NSLOT];
    logic [47:0] s_mac[NSLOT];
    int         s_next[NSLOT];
    int         head[NBKT];
    int         total;

    function automatic int bucket_hash(logic [47:0] mac);
        int sum;
        sum = 0;
        for (int b = 0; b < 6; b++) sum += mac[8*b +: 8];
        return sum % NBKT;
    endfunction

    // Apply one event to the shadow table and return what the block must answer.
    function automatic t_outcome apply_event(logic kind, logic [2:0] iface, logic [47:0] mac);
        t_outcome r;
        int bkt, cur, prev, hit, hprev, steps, f;
        bkt = bucket_hash(mac);
        cur = head[bkt]; prev = NSLOT; hit = NSLOT; hprev = NSLOT; steps = 0;
        while (cur < NSLOT && steps < NSLOT) begin
            if (s_iface[cur] == iface && s_mac[cur] == mac) begin
                hit = cur; hprev = prev; break;
            end
            prev = cur; cur = s_next[cur]; steps++;
        end
        r = '0;
        if (kind) begin
            if (hit < NSLOT) r.status = ST_PRESENT;
            else begin
                f = NSLOT;
                for (int i = 0; i < NSLOT; i++) if (!used[i]) begin f = i; break; end
                if (f >= NSLOT) r.status = ST_FULL;
                else begin
                    used[f] = 1; s_iface[f] = iface; s_mac[f] = mac; s_next[f] = NSLOT;
                    if (head[bkt] >= NSLOT) head[bkt] = f;
                    else begin
                        cur = head[bkt];
                        while (s_next[cur] < NSLOT) cur = s_next[cur];
                        s_next[cur] = f;
                    end
                    total++;
                    r.status = ST_ADDED; r.success = 1; r.slot = f[6:0];
                end
            end
        end else begin
            if (hit >= NSLOT) r.status = ST_ABSENT;
            else begin
                if (hprev >= NSLOT) head[bkt] = s_next[hit];
                else s_next[hprev] = s_next[hit];
                used[hit] = 0; s_iface[hit] = 0; s_mac[hit] = 0; s_next[hit] = NSLOT;
                total--;
                r.status = ST_REMOVED; r.success = 1; r.slot = hit[6:0];
            end
        end
        r.count = total[7:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch %s: got %0d want %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_results_seen = 0;
        o_pending = 0;
        total = 0;
        for (int i = 0; i < NSLOT; i++) begin
            used[i] = 0; s_next[i] = NSLOT;
        end
        for (int i = 0; i < NBKT; i++) head[i] = NSLOT;
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                outcome_q.push_back(apply_event(i_kind, i_iface, i_mac));
            if (i_res_valid && !i_res_stall) begin
                o_results_seen++;
                if (outcome_q.size() == 0) report_mismatch("unexpected result", 1, 0);
                else begin
                    want = outcome_q.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", i_status, want.status);
                    if (i_success !== want.success)
                        report_mismatch("success", i_success, want.success);
                    if (i_entry_slot !== want.slot)
                        report_mismatch("entry_slot", i_entry_slot, want.slot);
                    if (i_active_count !== want.count)
                        report_mismatch("active_count", i_active_count, want.count);
                end
            end
            o_pending = outcome_q.size();
        end
    end
endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic        kind = 0;
    logic [2:0]  iface = 0;
    logic [47:0] mac = 0;
    logic        res_valid;
    logic        res_stall = 0;
    logic [2:0]  status;
    logic        success;
    logic [6:0]  entry_slot;
    logic [7:0]  active_count;
    int          fail_count, pending, results_seen;

    // Idle/stall odds in percent; the hold-off flag forces a long receiver stall.
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 0;
    int          n_items = 0;

    // Small pool of known clients so disconnects and duplicate connects hit often.
    logic [2:0]  known_iface[32];
    logic [47:0] known_mac[32];

    always #4 i_clk = ~i_clk;

    mac_client_hash_table uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_iface(iface), .i_mac(mac),
        .o_res_valid(res_valid), .i_res_stall(res_stall),
        .o_status(status), .o_success(success),
        .o_entry_slot(entry_slot), .o_active_count(active_count)
    );

    mac_client_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_kind(kind), .i_iface(iface), .i_mac(mac),
        .i_res_valid(res_valid), .i_res_stall(res_stall),
        .i_status(status), .i_success(success),
        .i_entry_slot(entry_slot), .i_active_count(active_count),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen)
    );

    // Drive the receiver stall each edge; hold it high during a hold-off.
    always @(posedge i_clk) begin
        res_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // Offer one event; idle at random first, then hold it until transferred.
    // Valid stays high afterward; the next event or drain() decides it.
    task automatic send_event(logic k, logic [2:0] ifc, logic [47:0] m);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge i_clk);
        end
        in_valid <= 1; kind <= k; iface <= ifc; mac <= m;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        n_items++;
    endtask

    // Mostly reuse known clients; sometimes a fresh random MAC.
    task automatic send_random(int connect_pct);
        int j;
        logic [47:0] m;
        logic [2:0] ifc;
        j = $urandom_range(31);
        if ($urandom_range(99) < 80) begin
            ifc = known_iface[j]; m = known_mac[j];
        end else begin
            ifc = 3'($urandom_range(7)); m = 48'({$urandom, $urandom});
            if ($urandom_range(1)) begin
                known_iface[j] = ifc; known_mac[j] = m;
            end
        end
        send_event($urandom_range(99) < connect_pct, ifc, m);
    endtask

    // Drop valid and wait until every expected result has arrived.
    task automatic drain();
        in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Hold the receiver for a long stretch while events keep coming.
    initial begin
        wait (n_items >= 300);
        hold_off = 1;
        repeat (3000) @(posedge i_clk);
        hold_off = 0;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        for (int i = 0; i < 32; i++) begin
            known_iface[i] = 3'($urandom_range(7));
            known_mac[i] = 48'({$urandom, $urandom});
        end
        @(posedge i_clk);

        // Directed: extremes, duplicates, absent removal, same-bucket chains.
        send_event(1, 3'd0, 48'h0);
        send_event(1, 3'd0, 48'h0);
        send_event(1, 3'd7, 48'hFFFF_FFFF_FFFF);
        send_event(1, 3'd7, 48'h0);
        send_event(0, 3'd5, 48'h1234_5678_9ABC);
        send_event(1, 3'd1, 48'h0000_0000_0013);
        send_event(1, 3'd1, 48'h0000_0000_1300);
        send_event(1, 3'd1, 48'h1300_0000_0000);
        send_event(0, 3'd1, 48'h0000_0000_1300);
        send_event(0, 3'd1, 48'h0000_0000_0013);
        send_event(0, 3'd1, 48'h1300_0000_0000);
        send_event(0, 3'd7, 48'h0);
        send_event(0, 3'd7, 48'h0);
        send_event(1, 3'd2, 48'hAAAA_AAAA_AAAA);
        send_event(1, 3'd5, 48'h5555_5555_5555);
        send_event(0, 3'd0, 48'h0);
        drain();

        // Fill the pool past full, then check full status and slot reuse.
        for (int i = 0; i < 130; i++) send_event(1, i[2:0], {16'hF00D, 32'(i)});
        send_event(0, 3'd3, {16'hF00D, 32'd3});
        send_event(0, 3'd4, {16'hF00D, 32'd100});
        send_event(1, 3'd6, 48'h0102_0304_0506);
        send_event(1, 3'd6, 48'h0102_0304_0507);
        for (int i = 0; i < 130; i++) send_event(0, i[2:0], {16'hF00D, 32'(i)});
        send_event(0, 3'd6, 48'h0102_0304_0506);
        send_event(0, 3'd2, 48'hAAAA_AAAA_AAAA);
        send_event(0, 3'd5, 48'h5555_5555_5555);
        send_event(0, 3'd7, 48'hFFFF_FFFF_FFFF);
        drain();

        // Random phases: no idling, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 65 : (ph == 3) ? 35 : 0;
            recv_stall_pct = (ph == 2) ? 65 : (ph == 3) ? 35 : 0;
            for (int i = 0; i < 250; i++) send_random(i < 125 ? 70 : 35);
            // Sender pauses until the block has answered everything.
            drain();
        end
        send_idle_pct = 0; recv_stall_pct = 0;
        for (int i = 0; i < 120; i++) send_random(50);

        drain();
        repeat (300) @(posedge i_clk);
        $display("Covered %0d events (%0d results): pool fill/overflow, chains,", n_items,
                 results_seen);
        $display("duplicates, absent removals, idle and stall phases, long hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Timeout guard: far beyond the slowest legal run.
    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
